>>> design/ncov_pkg.sv
// shared types and constants for the running mean and covariance block
`default_nettype none

package ncov_pkg;

    localparam int VAL_W      = 32;
    localparam int NODE_W     = 12;
    localparam int STEP_W     = 32;
    localparam int IV_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_MEAN   = 4;
    localparam int NUM_MOM    = 7;
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 33;
    localparam int MEAN_ROW_W = NUM_MEAN * VAL_W;
    localparam int MOM_ROW_W  = NUM_MOM * VAL_W;
    localparam int LAST_K     = NUM_MEAN + NUM_MOM - 1;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_SAMPLE        = 2'd0,
        OP_RESET_MEANS   = 2'd1,
        OP_RESET_MOMENTS = 2'd2,
        OP_READ          = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MEANS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MOMENTS = 2'd2;

    // classified command from the front to the back
    typedef struct packed {
        op_t                             op;
        logic                            in_range;
        logic [NODE_W-1:0]               node;
        logic [STEP_W-1:0]               time_step;
        logic [NUM_MEAN-1:0][VAL_W-1:0]  vals;
    } cmd_t;

    // configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [STEP_W-1:0]    data;
    } cfg_t;

    // result item
    typedef struct packed {
        logic [NODE_W-1:0]              node;
        logic [NUM_MEAN-1:0][VAL_W-1:0] mean;
        logic [NUM_MOM-1:0][VAL_W-1:0]  mom;
    } res_t;

endpackage

`default_nettype wire

>>> design/ncov_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module ncov_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/ncov_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module ncov_div import ncov_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] acc_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic             ge;
    logic [DVS_W:0]   diff;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, acc_reg[DVD_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

`default_nettype wire

>>> design/ncov_front.sv
// front end: accepts input transactions, classifies them and queues commands
`default_nettype none

module ncov_front import ncov_pkg::*; #(
    parameter int NUM_NODES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire logic [1:0]        op,
    input  wire logic [NODE_W-1:0] node,
    input  wire logic [STEP_W-1:0] time_step,
    input  wire logic [VAL_W-1:0]  vel_x,
    input  wire logic [VAL_W-1:0]  vel_y,
    input  wire logic [VAL_W-1:0]  vel_z,
    input  wire logic [VAL_W-1:0]  pressure,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output cmd_t                   cmd
);

    localparam int QDEPTH = 2;

    cmd_t       q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    cmd_t       cls;
    logic [20:0] node_ext;
    logic        push;
    logic        pop;

    // classification
    always_comb
    begin
        node_ext         = {9'd0, node};
        cls.op           = op_t'(op);
        cls.in_range     = node_ext < 21'(NUM_NODES);
        cls.node         = node;
        cls.time_step    = time_step;
        cls.vals         = {pressure, vel_z, vel_y, vel_x};
    end

    assign sample_ready = count_reg != 2'(QDEPTH);
    assign push         = sample_valid && sample_ready;
    assign cmd_valid    = count_reg != 2'd0;
    assign pop          = cmd_valid && cmd_ready;
    assign cmd          = q_reg[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> design/ncov_back.sv
// back end: statistics memories, update sequencer and result register
`default_nettype none

module ncov_back import ncov_pkg::*; #(
    parameter int NUM_NODES = 4096,
    parameter int FRAC_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int AW = NUM_NODES > 1 ? $clog2(NUM_NODES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RRD, S_RESP, S_SRD, S_CNT_M, S_CNT_S, S_DD,
        S_PT, S_MUL, S_NUM, S_ABS, S_DIVST, S_DIVW, S_WB, S_WRITE
    } state_t;

    state_t          state_reg;
    logic [3:0]      k_reg;
    logic            clr_m_reg;
    logic            clr_s_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic            res_valid_reg;
    logic            oor_reg;
    logic [IV_W-1:0] iv_reg;
    logic [STEP_W-1:0] refm_reg;
    logic [STEP_W-1:0] refs_reg;

    cmd_t                     cmd_reg;
    logic signed [VAL_W-1:0]  mrow_reg [NUM_MEAN];
    logic signed [VAL_W-1:0]  srow_reg [NUM_MOM];
    logic signed [VAL_W:0]    d_reg [NUM_MEAN];
    logic [STEP_W-1:0]        nm_reg;
    logic [STEP_W-1:0]        ns_reg;
    logic signed [67:0]       prod_reg;
    logic signed [67:0]       num_reg;
    logic                     pneg_reg;
    logic                     nneg_reg;
    logic [DVD_W-1:0]         mag_reg;
    logic signed [VAL_W-1:0]  add_reg;
    logic [DVD_W-1:0]         q_reg;
    res_t                     res_reg;

    logic [MEAN_ROW_W-1:0] mean_rdata;
    logic [MOM_ROW_W-1:0]  mom_rdata;
    logic [MEAN_ROW_W-1:0] mean_wdata;
    logic [MOM_ROW_W-1:0]  mom_wdata;
    logic                  mean_we;
    logic                  mom_we;
    logic                  ram_re;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [20:0]           in_node_ext;
    logic [20:0]           cur_node_ext;

    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quo;

    logic                  is_mean;
    logic [1:0]            kk;
    logic [2:0]            jj;
    logic signed [VAL_W:0] da;
    logic signed [VAL_W:0] db;
    logic [VAL_W:0]        abs_da;
    logic [VAL_W:0]        abs_db;
    logic signed [33:0]    mul_a;
    logic signed [33:0]    mul_b;
    logic [IV_W-1:0]       iv_eff;
    logic [STEP_W-1:0]     elapsed;
    logic [STEP_W-1:0]     n_cur;
    logic [DVS_W-1:0]      np1;
    logic [64:0]           pt_rnd;
    logic [64:0]           pt_r;
    logic signed [VAL_W-1:0] pt_val;
    logic                  q_big;
    logic signed [VAL_W-1:0] q_val;
    logic                  res_load;

    // update position decode
    always_comb
    begin
        is_mean = k_reg < 4'(NUM_MEAN);
        kk      = k_reg[1:0];
        jj      = 3'(k_reg - 4'(NUM_MEAN));
        unique case (jj)
            3'd0:    begin da = d_reg[0]; db = d_reg[0]; end
            3'd1:    begin da = d_reg[1]; db = d_reg[1]; end
            3'd2:    begin da = d_reg[2]; db = d_reg[2]; end
            3'd3:    begin da = d_reg[0]; db = d_reg[1]; end
            3'd4:    begin da = d_reg[0]; db = d_reg[2]; end
            3'd5:    begin da = d_reg[1]; db = d_reg[2]; end
            default: begin da = d_reg[3]; db = d_reg[3]; end
        endcase
        abs_da = da[VAL_W] ? 33'(-da) : 33'(da);
        abs_db = db[VAL_W] ? 33'(-db) : 33'(db);
    end

    // shared multiplier operands
    always_comb
    begin
        if (state_reg == S_DD)
        begin
            mul_a = signed'({1'b0, abs_da});
            mul_b = signed'({1'b0, abs_db});
        end
        else if (is_mean)
        begin
            mul_a = 34'(mrow_reg[kk]);
            mul_b = signed'({2'b00, nm_reg});
        end
        else
        begin
            mul_a = 34'(srow_reg[jj]);
            mul_b = signed'({2'b00, ns_reg});
        end
    end

    // rounded and saturated deviation product
    always_comb
    begin
        pt_rnd = {1'b0, prod_reg[63:0]} + (65'd1 << (FRAC_BITS - 1));
        pt_r   = pt_rnd >> FRAC_BITS;
        if (pneg_reg)
        begin
            if ((|pt_r[64:32]) || (pt_r[31:0] > 32'h8000_0000))
            begin
                pt_val = 32'sh8000_0000;
            end
            else
            begin
                pt_val = signed'(-pt_r[31:0]);
            end
        end
        else if ((|pt_r[64:31]))
        begin
            pt_val = 32'sh7fff_ffff;
        end
        else
        begin
            pt_val = signed'(pt_r[31:0]);
        end
    end

    // divider operands and saturated quotient
    always_comb
    begin
        iv_eff  = (iv_reg == '0) ? IV_W'(1) : iv_reg;
        if (state_reg == S_SRD)
        begin
            elapsed = (cmd_reg.time_step >= refm_reg) ? cmd_reg.time_step - refm_reg : '0;
        end
        else
        begin
            elapsed = (cmd_reg.time_step >= refs_reg) ? cmd_reg.time_step - refs_reg : '0;
        end
        n_cur   = is_mean ? nm_reg : ns_reg;
        np1     = {1'b0, n_cur} + 33'd1;
        div_start = (state_reg == S_SRD) || (state_reg == S_CNT_M && div_done)
                    || (state_reg == S_DIVST);
        if (state_reg == S_DIVST)
        begin
            div_dividend = mag_reg + {32'd0, np1[32:1]};
            div_divisor  = np1;
        end
        else
        begin
            div_dividend = {32'd0, elapsed};
            div_divisor  = {17'd0, iv_eff};
        end
        q_big = |q_reg[63:31];
        if (nneg_reg)
        begin
            q_val = q_big ? 32'sh8000_0000 : signed'(-q_reg[31:0]);
        end
        else
        begin
            q_val = q_big ? 32'sh7fff_ffff : signed'(q_reg[31:0]);
        end
    end

    // memory ports
    always_comb
    begin
        in_node_ext  = {9'd0, cmd.node};
        cur_node_ext = {9'd0, cmd_reg.node};
        raddr   = in_node_ext[AW-1:0];
        ram_re  = state_reg == S_IDLE && cmd_valid && cmd.in_range
                  && (cmd.op == OP_SAMPLE || cmd.op == OP_READ);
        waddr   = (state_reg == S_CLEAR) ? clr_addr_reg : cur_node_ext[AW-1:0];
        mean_we = (state_reg == S_CLEAR && clr_m_reg) || state_reg == S_WRITE;
        mom_we  = (state_reg == S_CLEAR && clr_s_reg) || state_reg == S_WRITE;
        for (int i = 0; i < NUM_MEAN; i++)
        begin
            mean_wdata[i*VAL_W +: VAL_W] = (state_reg == S_CLEAR) ? '0 : mrow_reg[i];
        end
        for (int i = 0; i < NUM_MOM; i++)
        begin
            mom_wdata[i*VAL_W +: VAL_W] = (state_reg == S_CLEAR) ? '0 : srow_reg[i];
        end
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign res_load  = state_reg == S_RESP && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    ncov_ram #(.WIDTH(MEAN_ROW_W), .DEPTH(NUM_NODES)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (waddr),
        .wdata (mean_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (mean_rdata)
    );

    ncov_ram #(.WIDTH(MOM_ROW_W), .DEPTH(NUM_NODES)) u_mom_ram (
        .clk   (clk),
        .we    (mom_we),
        .waddr (waddr),
        .wdata (mom_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (mom_rdata)
    );

    ncov_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            clr_m_reg     <= 1'b1;
            clr_s_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
            oor_reg       <= 1'b0;
            iv_reg        <= IV_W'(1);
            refm_reg      <= '0;
            refs_reg      <= '0;
        end
        else
        begin
            if (cfg.we)
            begin
                unique case (cfg.index)
                    CFG_INTERVAL:      iv_reg   <= cfg.data[IV_W-1:0];
                    CFG_START_MEANS:   refm_reg <= cfg.data;
                    CFG_START_MOMENTS: refs_reg <= cfg.data;
                    default:           ;
                endcase
            end
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(NUM_NODES - 1))
                    begin
                        clr_m_reg <= 1'b0;
                        clr_s_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.op)
                            OP_RESET_MEANS:
                            begin
                                refm_reg     <= cmd.time_step;
                                clr_m_reg    <= 1'b1;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            OP_RESET_MOMENTS:
                            begin
                                refs_reg     <= cmd.time_step;
                                clr_s_reg    <= 1'b1;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            OP_SAMPLE:
                            begin
                                if (cmd.in_range)
                                begin
                                    state_reg <= S_SRD;
                                end
                            end
                            OP_READ:
                            begin
                                oor_reg   <= !cmd.in_range;
                                state_reg <= cmd.in_range ? S_RRD : S_RESP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RRD:   state_reg <= S_RESP;
                S_RESP:
                begin
                    if (res_load)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SRD:   state_reg <= S_CNT_M;
                S_CNT_M:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_CNT_S;
                    end
                end
                S_CNT_S:
                begin
                    if (div_done)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_DD:    state_reg <= S_PT;
                S_PT:    state_reg <= S_MUL;
                S_MUL:   state_reg <= S_NUM;
                S_NUM:   state_reg <= S_ABS;
                S_ABS:   state_reg <= S_DIVST;
                S_DIVST: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (k_reg == 4'(LAST_K))
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg + 4'd1 < 4'(NUM_MEAN)) ? S_MUL : S_DD;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_reg <= cmd;
                end
            end
            S_SRD, S_RRD:
            begin
                for (int i = 0; i < NUM_MEAN; i++)
                begin
                    mrow_reg[i] <= signed'(mean_rdata[i*VAL_W +: VAL_W]);
                end
                for (int i = 0; i < NUM_MOM; i++)
                begin
                    srow_reg[i] <= signed'(mom_rdata[i*VAL_W +: VAL_W]);
                end
            end
            S_CNT_M:
            begin
                if (div_done)
                begin
                    nm_reg <= div_quo[STEP_W-1:0];
                end
            end
            S_CNT_S:
            begin
                if (div_done)
                begin
                    ns_reg <= div_quo[STEP_W-1:0];
                end
            end
            S_DD:
            begin
                prod_reg <= mul_a * mul_b;
                pneg_reg <= da[VAL_W] ^ db[VAL_W];
            end
            S_PT:    add_reg <= pt_val;
            S_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                if (is_mean)
                begin
                    add_reg <= signed'(cmd_reg.vals[kk]);
                end
            end
            S_NUM:   num_reg <= prod_reg + 68'(add_reg);
            S_ABS:
            begin
                nneg_reg <= num_reg[67];
                mag_reg  <= num_reg[67] ? 64'(-num_reg) : num_reg[63:0];
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    q_reg <= div_quo;
                end
            end
            S_WB:
            begin
                if (is_mean)
                begin
                    mrow_reg[kk] <= q_val;
                    d_reg[kk]    <= 33'(signed'(cmd_reg.vals[kk])) - 33'(q_val);
                end
                else
                begin
                    srow_reg[jj] <= q_val;
                end
            end
            S_RESP:
            begin
                if (res_load)
                begin
                    res_reg.node <= cmd_reg.node;
                    for (int i = 0; i < NUM_MEAN; i++)
                    begin
                        res_reg.mean[i] <= oor_reg ? '0 : mrow_reg[i];
                    end
                    for (int i = 0; i < NUM_MOM; i++)
                    begin
                        res_reg.mom[i] <= oor_reg ? '0 : srow_reg[i];
                    end
                end
            end
            default: ;
        endcase
    end

    // a row is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !(mean_we || mom_we))
        else $error("ram read during write");

    // divider completions arrive only where the sequencer waits for them
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_CNT_M || state_reg == S_CNT_S || state_reg == S_DIVW))
        else $error("unexpected divider completion");

    // a result only appears after the response state
    a_res_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result without read");

    // the update index stays within the statistics of one node
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= 4'(LAST_K))
        else $error("update index out of range");

endmodule

`default_nettype wire

>>> design/node_running_mean_covariance.sv
// top level of the per-node running mean and covariance block
`default_nettype none

// Per-node running statistics of velocity and pressure in signed fixed point.
// Transactions pass through a two-entry command queue to a sequencer that owns two
// row memories (four means and seven second moments per node). A sample takes two
// count divisions and eleven rounded divisions by n+1, each done by one shared
// divider at one quotient bit per cycle (64 steps per division), with a shared
// multiplier ahead of it. After reset, and after each reset-means or reset-moments
// transaction, a clearing pass writes one row per cycle over all NUM_NODES rows,
// during which no transaction is taken from the queue; configuration writes are
// taken at any time.
module node_running_mean_covariance import ncov_pkg::*; #(
    parameter int NUM_NODES = 4096,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [STEP_W-1:0]    cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire logic [1:0]           op,
    input  wire logic [NODE_W-1:0]    node,
    input  wire logic [STEP_W-1:0]    time_step,
    input  wire logic [VAL_W-1:0]     vel_x,
    input  wire logic [VAL_W-1:0]     vel_y,
    input  wire logic [VAL_W-1:0]     vel_z,
    input  wire logic [VAL_W-1:0]     pressure,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [NODE_W-1:0]         out_node,
    output logic [VAL_W-1:0]          mean_vx,
    output logic [VAL_W-1:0]          mean_vy,
    output logic [VAL_W-1:0]          mean_vz,
    output logic [VAL_W-1:0]          var_xx,
    output logic [VAL_W-1:0]          var_yy,
    output logic [VAL_W-1:0]          var_zz,
    output logic [VAL_W-1:0]          cov_xy,
    output logic [VAL_W-1:0]          cov_xz,
    output logic [VAL_W-1:0]          cov_yz,
    output logic [VAL_W-1:0]          mean_press,
    output logic [VAL_W-1:0]          var_press
);

    cfg_t cfg;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    res_t res;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ncov_front #(.NUM_NODES(NUM_NODES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .op           (op),
        .node         (node),
        .time_step    (time_step),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .pressure     (pressure),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    ncov_back #(.NUM_NODES(NUM_NODES), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (result_valid),
        .res_ready (result_ready),
        .res       (res)
    );

    // result fields
    assign out_node   = res.node;
    assign mean_vx    = res.mean[0];
    assign mean_vy    = res.mean[1];
    assign mean_vz    = res.mean[2];
    assign mean_press = res.mean[3];
    assign var_xx     = res.mom[0];
    assign var_yy     = res.mom[1];
    assign var_zz     = res.mom[2];
    assign cov_xy     = res.mom[3];
    assign cov_xz     = res.mom[4];
    assign cov_yz     = res.mom[5];
    assign var_press  = res.mom[6];

endmodule

`default_nettype wire
